/* design/bbsf_pkg.sv */
// Shared types and constants for the bounded byte stream FIFO.
// Used by the controller, the top level and the checker; depends on nothing else.
`timescale 1ns / 1ps

package bbsf_pkg;

    // Ring size and the widths that follow from it.
    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed widths of the port fields.
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int AMOUNT_W = 13;
    localparam int OFFSET_W = 12;
    localparam int CAP_W    = 13;
    localparam int COUNT_W  = 13;
    localparam int TOTAL_W  = 64;

    // Width wide enough to compare any count field against the fill.
    localparam int CMP_W = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = KIND_W'(0),
        KIND_READ   = KIND_W'(1),
        KIND_PEEK   = KIND_W'(2),
        KIND_POP    = KIND_W'(3),
        KIND_END    = KIND_W'(4),
        KIND_STATUS = KIND_W'(5)
    } t_kind;

    // Ring memory request issued when an item is accepted.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Result of one beat, all but the byte that comes back from the ring.
    typedef struct packed {
        logic               use_data;
        logic               done;
        logic [COUNT_W-1:0] removed;
        logic [COUNT_W-1:0] buffered;
        logic [COUNT_W-1:0] free;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
        logic               closed;
        logic               eos;
    } t_result;

endpackage

/* design/bbsf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bbsf_ctrl.sv */
// Pointer and counter unit: head, tail, fill, totals, closed flag and capacity.
// Decodes each beat, updates the state and issues the ring memory request.
// Depends on bbsf_pkg.
`timescale 1ns / 1ps

module bbsf_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbsf_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic                            i_take,
    input  logic [bbsf_pkg::KIND_W-1:0]     i_kind,
    input  logic [bbsf_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic [bbsf_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [bbsf_pkg::OFFSET_W-1:0]   i_offset,
    output bbsf_pkg::t_ram_req              o_ram,
    output bbsf_pkg::t_result               o_res
);

    logic [bbsf_pkg::CNT_W-1:0]   r_cap;
    logic [bbsf_pkg::ADDR_W-1:0]  r_head, n_head;
    logic [bbsf_pkg::ADDR_W-1:0]  r_tail, n_tail;
    logic [bbsf_pkg::CNT_W-1:0]   r_fill, n_fill;
    logic [bbsf_pkg::TOTAL_W-1:0] r_total_written, n_total_written;
    logic [bbsf_pkg::TOTAL_W-1:0] r_total_read, n_total_read;
    logic                         r_closed, n_closed;

    bbsf_pkg::t_kind              kind;
    logic [bbsf_pkg::CMP_W-1:0]   fill_cmp;
    logic [bbsf_pkg::CNT_W-1:0]   clip;
    logic [bbsf_pkg::CNT_W-1:0]   cap_eff;
    bbsf_pkg::t_ram_req           ram;
    bbsf_pkg::t_result            res;

    // Advance a pointer around a ring of cap entries; inc never exceeds cap.
    function automatic logic [bbsf_pkg::ADDR_W-1:0] wrap_add(
        input logic [bbsf_pkg::ADDR_W-1:0] ptr,
        input logic [bbsf_pkg::CNT_W-1:0]  inc,
        input logic [bbsf_pkg::CNT_W-1:0]  cap
    );
        logic [bbsf_pkg::CNT_W:0] sum;
        sum = (bbsf_pkg::CNT_W + 1)'(ptr) + (bbsf_pkg::CNT_W + 1)'(inc);
        if (sum >= (bbsf_pkg::CNT_W + 1)'(cap)) begin
            sum = sum - (bbsf_pkg::CNT_W + 1)'(cap);
        end
        return bbsf_pkg::ADDR_W'(sum);
    endfunction

    // A capacity of zero behaves as one, and anything above the ring as the ring.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cap_eff = bbsf_pkg::CNT_W'(1);
        end else if (bbsf_pkg::CMP_W'(i_cfg_wdata) > bbsf_pkg::CMP_W'(bbsf_pkg::DEPTH)) begin
            cap_eff = bbsf_pkg::CNT_W'(bbsf_pkg::DEPTH);
        end else begin
            cap_eff = bbsf_pkg::CNT_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        kind     = bbsf_pkg::t_kind'(i_kind);
        fill_cmp = bbsf_pkg::CMP_W'(r_fill);
        clip     = (bbsf_pkg::CMP_W'(i_amount) < fill_cmp) ?
                   bbsf_pkg::CNT_W'(i_amount) : r_fill;

        n_head          = r_head;
        n_tail          = r_tail;
        n_fill          = r_fill;
        n_total_written = r_total_written;
        n_total_read    = r_total_read;
        n_closed        = r_closed;

        ram       = '0;
        ram.waddr = r_tail;
        ram.wdata = i_byte_value;
        ram.raddr = r_head;

        res          = '0;

        case (kind)
            bbsf_pkg::KIND_WRITE: begin
                if (r_fill < r_cap) begin
                    ram.we          = 1'b1;
                    n_tail          = wrap_add(r_tail, bbsf_pkg::CNT_W'(1), r_cap);
                    n_fill          = r_fill + bbsf_pkg::CNT_W'(1);
                    n_total_written = r_total_written + bbsf_pkg::TOTAL_W'(1);
                    res.done        = 1'b1;
                end
            end
            bbsf_pkg::KIND_READ: begin
                if (r_fill != '0) begin
                    ram.re       = 1'b1;
                    n_head       = wrap_add(r_head, bbsf_pkg::CNT_W'(1), r_cap);
                    n_fill       = r_fill - bbsf_pkg::CNT_W'(1);
                    n_total_read = r_total_read + bbsf_pkg::TOTAL_W'(1);
                    res.done     = 1'b1;
                    res.use_data = 1'b1;
                    res.removed  = bbsf_pkg::COUNT_W'(1);
                end
            end
            bbsf_pkg::KIND_PEEK: begin
                if (bbsf_pkg::CMP_W'(i_offset) < fill_cmp) begin
                    ram.re       = 1'b1;
                    ram.raddr    = wrap_add(r_head, bbsf_pkg::CNT_W'(i_offset), r_cap);
                    res.done     = 1'b1;
                    res.use_data = 1'b1;
                end
            end
            bbsf_pkg::KIND_POP: begin
                n_head       = wrap_add(r_head, clip, r_cap);
                n_fill       = r_fill - clip;
                n_total_read = r_total_read + bbsf_pkg::TOTAL_W'(clip);
                res.removed  = bbsf_pkg::COUNT_W'(clip);
            end
            bbsf_pkg::KIND_END: begin
                n_closed = 1'b1;
            end
            default: begin
                // Status and the unused codes only report.
            end
        endcase

        res.buffered      = bbsf_pkg::COUNT_W'(n_fill);
        res.free          = bbsf_pkg::COUNT_W'(r_cap - n_fill);
        res.total_written = n_total_written;
        res.total_read    = n_total_read;
        res.closed        = n_closed;
        res.eos           = n_closed && (n_fill == '0);

        ram.we = ram.we && i_take;
        ram.re = ram.re && i_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap           <= bbsf_pkg::CNT_W'(bbsf_pkg::DEPTH);
            r_head          <= '0;
            r_tail          <= '0;
            r_fill          <= '0;
            r_total_written <= '0;
            r_total_read    <= '0;
            r_closed        <= 1'b0;
        end else if (i_cfg_we) begin
            // A new capacity empties the ring; totals and closed are kept.
            r_cap  <= cap_eff;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_take) begin
            r_head          <= n_head;
            r_tail          <= n_tail;
            r_fill          <= n_fill;
            r_total_written <= n_total_written;
            r_total_read    <= n_total_read;
            r_closed        <= n_closed;
        end
    end

    assign o_ram = ram;
    assign o_res = res;

endmodule

/* design/bounded_byte_stream_fifo.sv */
// Bounded byte stream FIFO: ring buffer with write, read, peek, pop, close and status beats.
// A result passes from the pointer unit into the result stage register and then into the
// output register before it is offered.
// Accepts one beat per cycle; input stalls only while both the result stage and the
// output register are held. Reset is synchronous, active low: pointers, fill, totals
// and closed flag clear, capacity returns to the ring size.
`timescale 1ns / 1ps

module bounded_byte_stream_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Capacity register write.
    input  logic                            i_cfg_we,
    input  logic [bbsf_pkg::CAP_W-1:0]      i_cfg_wdata,
    // Input beats.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bbsf_pkg::KIND_W-1:0]     i_kind,
    input  logic [bbsf_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic [bbsf_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [bbsf_pkg::OFFSET_W-1:0]   i_offset,
    // Result beats.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bbsf_pkg::BYTE_W-1:0]     o_data_byte,
    output logic                            o_done_res,
    output logic [bbsf_pkg::COUNT_W-1:0]    o_removed_count,
    output logic [bbsf_pkg::COUNT_W-1:0]    o_buffered_count,
    output logic [bbsf_pkg::COUNT_W-1:0]    o_free_space,
    output logic [bbsf_pkg::TOTAL_W-1:0]    o_total_written,
    output logic [bbsf_pkg::TOTAL_W-1:0]    o_total_read,
    output logic                            o_input_closed,
    output logic                            o_end_of_stream
);

    // The pointer unit decides every beat in the cycle it is accepted and
    // commits its state at once, so the next beat sees the updated pointers.
    // A write lands in the ring at the accept edge and a read of that same
    // entry can only be issued by a later beat, so no forwarding is needed.

    logic               take;
    logic               p_move;
    logic               r_p_valid;
    bbsf_pkg::t_result  r_p_res;
    logic               r_o_valid;
    bbsf_pkg::t_result  r_o_res;
    logic [bbsf_pkg::BYTE_W-1:0] r_o_data;
    logic [bbsf_pkg::BYTE_W-1:0] ram_rdata;
    bbsf_pkg::t_ram_req ram_req;
    bbsf_pkg::t_result  res;

    // The result stage waits for the ring read data; it moves to the output
    // register whenever that register is empty or being taken. The ring read
    // data holds until the next read, which only a new accepted beat issues.
    assign p_move     = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_p_valid && !p_move;
    assign take       = i_in_valid && !o_in_stall;

    bbsf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_take       (take),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .i_amount     (i_amount),
        .i_offset     (i_offset),
        .o_ram        (ram_req),
        .o_res        (res)
    );

    bbsf_ram #(
        .WIDTH (bbsf_pkg::BYTE_W),
        .DEPTH (bbsf_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Valid bits of the result stage and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers; the byte is zero unless a read or peek found one.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p_res <= res;
        end
        if (p_move) begin
            r_o_res  <= r_p_res;
            r_o_data <= r_p_res.use_data ? ram_rdata : '0;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_data_byte      = r_o_data;
    assign o_done_res       = r_o_res.done;
    assign o_removed_count  = r_o_res.removed;
    assign o_buffered_count = r_o_res.buffered;
    assign o_free_space     = r_o_res.free;
    assign o_total_written  = r_o_res.total_written;
    assign o_total_read     = r_o_res.total_read;
    assign o_input_closed   = r_o_res.closed;
    assign o_end_of_stream  = r_o_res.eos;

endmodule

/* design/bbsf_chk.sv */
// Port-level checker for the bounded byte stream FIFO, bound to the top level.
// Depends on bbsf_pkg and on bounded_byte_stream_fifo.
`timescale 1ns / 1ps

module bbsf_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [bbsf_pkg::BYTE_W-1:0]  o_data_byte,
    input logic                         o_done_res,
    input logic [bbsf_pkg::COUNT_W-1:0] o_buffered_count,
    input logic [bbsf_pkg::TOTAL_W-1:0] o_total_written,
    input logic                         o_input_closed,
    input logic                         o_end_of_stream
);

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A beat that found no byte carries a zero byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_data_byte == '0))
        else $error("nonzero byte on a beat without a found byte");

    // End of stream means closed and empty, and nothing else.
    a_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_of_stream == (o_input_closed && (o_buffered_count == '0))))
        else $error("end of stream flag disagrees with closed flag and fill");

    // A held result stays offered and keeps its total of written bytes.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_total_written)))
        else $error("stalled result changed or vanished");

endmodule

bind bounded_byte_stream_fifo bbsf_chk u_bbsf_chk (.*);
